// ----- rtl/core/postfix_expression_evaluator_core_assert.svh -----
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core_assert
// Assertion macros for the postfix expression evaluator.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
// Implication checked every clock, muted in reset.
`define PEE_ASSERT_IMP(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, muted in reset.
`define PEE_ASSERT_NXT(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- rtl/core/pee_pkg.sv -----
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and codes of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;
   localparam logic [1:0] REQ_PUSH = 2'd0;
   localparam logic [1:0] REQ_OP   = 2'd1;
   localparam logic [1:0] REQ_END  = 2'd2;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_POW = 3'd4;
   localparam logic [2:0] OP_REM = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_DIVZERO   = 2'd2;
   localparam logic [1:0] ST_OVERFLOW  = 2'd3;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] operand;
      logic [2:0]         op_code;
   } req_type_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
   } rsp_type;

   // controller -> datapath commands
   typedef struct packed {
      logic push;       // write operand at count
      logic rd_b;       // read entry count-1
      logic rd_a;       // read entry count-2
      logic cap_b;      // capture read data as b
      logic cap_a;      // capture read data as a
      logic start;      // start arithmetic
      logic wr_res;     // write result at count-2, count -= 1
      logic rd_0;       // read entry 0
      logic clear;      // count <= 0
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic full;
      logic lt2;
      logic one;
      logic done;
      logic divz;
   } sts_type;
endpackage

// ----- rtl/core/postfix_expression_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// RPN calculator: operand stack in RAM, sequencer and multi-cycle ALU.
// ----------------------------------------------------------------------------
//  channel | dir | payload                   | transaction
//  req_    | in  | req_type, operand, op_code | one token
//  rsp_    | out | value, status              | one per end token
//
// Push, unused and rejected tokens are handled in the idle state. An operator
// reads both operands, starts the ALU and waits for it: add/sub/mul, a zero
// divisor or a negative exponent in one step, div/rem one quotient bit a cycle,
// power by square-and-multiply over exponent bits. An end token reads entry 0.
// Reset clears stack count, sticky error and the valid flags; the stack RAM
// is not cleared. A stalled result holds in its register; a new end token
// waits only if that register is still full.
module postfix_expression_evaluator_core #(
   parameter int STACK_DEPTH = 64,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pee_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pee_pkg::rsp_type      rsp_data
);
   pee_pkg::cmd_type      cmd;
   pee_pkg::sts_type      sts;
   logic [2:0]            op_code;
   logic [DATA_WIDTH-1:0] rd_value;

   pee_ctrl #(.DATA_WIDTH(DATA_WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .op_code   (op_code),
      .sts       (sts),
      .rd_value  (rd_value)
   );

   pee_datapath #(.STACK_DEPTH(STACK_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .operand  (req_data.operand),
      .op_code  (op_code),
      .sts      (sts),
      .rd_value (rd_value)
   );
endmodule

// ----- rtl/core/pee_ram.sv -----
// ----------------------------------------------------------------------------
// pee_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module pee_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/pee_alu.sv -----
// ----------------------------------------------------------------------------
// pee_alu
// Multi-cycle arithmetic: add/sub in one step, mul in one, div/rem by
// restoring division one bit a cycle, power by square-and-multiply.
// ----------------------------------------------------------------------------
module pee_alu #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0]            op_code,
   input  logic [DATA_WIDTH-1:0] a,
   input  logic [DATA_WIDTH-1:0] b,
   output logic                  done,
   output logic                  divz,
   output logic [DATA_WIDTH-1:0] result
);
   localparam int CW = $clog2(DATA_WIDTH + 1);

   typedef enum logic [4:0] {
      A_IDLE = 5'b00001,
      A_DIV  = 5'b00010,
      A_POWM = 5'b00100,
      A_POWS = 5'b01000,
      A_DONE = 5'b10000
   } alu_state_type;

   alu_state_type        state_ff, state_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;     // quotient / power result
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;     // remainder / power base
   logic [DATA_WIDTH-1:0] den_ff, den_in;     // divisor magnitude / exponent
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [2:0]            op_ff, op_in;
   logic                  sa_ff, sa_in, sb_ff, sb_in;
   logic [DATA_WIDTH-1:0] res_ff, res_in;
   logic                  divz_ff, divz_in;

   logic [DATA_WIDTH-1:0] ma, mb, prod;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH-1:0] mul_x, mul_y;

   assign ma = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
   assign mb = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
   assign trial = {rem_ff, acc_ff[DATA_WIDTH-1]} - {1'b0, den_ff};

   always_comb begin
      mul_x = a;
      mul_y = b;
      if (state_ff == A_POWM) begin
         mul_x = acc_ff;
         mul_y = rem_ff;
      end else if (state_ff == A_POWS) begin
         mul_x = rem_ff;
         mul_y = rem_ff;
      end
   end
   assign prod = mul_x * mul_y;

   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      op_in = op_ff;
      sa_in = sa_ff;
      sb_in = sb_ff;
      res_in = res_ff;
      divz_in = divz_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (start) begin
               op_in = op_code;
               divz_in = 1'b0;
               sa_in = a[DATA_WIDTH-1];
               sb_in = b[DATA_WIDTH-1];
               state_in = A_DONE;
               priority case (op_code)
                  pee_pkg::OP_ADD: res_in = a + b;
                  pee_pkg::OP_SUB: res_in = a - b;
                  pee_pkg::OP_MUL: res_in = prod;
                  pee_pkg::OP_POW: begin
                     if (b[DATA_WIDTH-1]) begin
                        if (a == DATA_WIDTH'(1)) res_in = DATA_WIDTH'(1);
                        else if (&a) res_in = b[0] ? a : DATA_WIDTH'(1);
                        else res_in = '0;
                     end else begin
                        acc_in = DATA_WIDTH'(1);
                        rem_in = a;
                        den_in = b;
                        state_in = A_POWM;
                     end
                  end
                  default: begin
                     if (b == '0) begin
                        divz_in = 1'b1;
                     end else begin
                        acc_in = ma;
                        rem_in = '0;
                        den_in = mb;
                        cnt_in = CW'(DATA_WIDTH);
                        state_in = A_DIV;
                     end
                  end
               endcase
            end
         end
         A_DIV: begin
            if (!trial[DATA_WIDTH]) begin
               rem_in = trial[DATA_WIDTH-1:0];
               acc_in = {acc_ff[DATA_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[DATA_WIDTH-2:0], acc_ff[DATA_WIDTH-1]};
               acc_in = {acc_ff[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = A_DONE;
               if (op_ff == pee_pkg::OP_DIV) begin
                  res_in = (sa_ff != sb_ff) ? (~acc_in + 1'b1) : acc_in;
               end else begin
                  res_in = sa_ff ? (~rem_in + 1'b1) : rem_in;
               end
            end
         end
         A_POWM: begin
            if (den_ff == '0) begin
               res_in = acc_ff;
               state_in = A_DONE;
            end else begin
               if (den_ff[0]) acc_in = prod;
               state_in = A_POWS;
            end
         end
         A_POWS: begin
            rem_in = prod;
            den_in = den_ff >> 1;
            state_in = A_POWM;
         end
         A_DONE: state_in = A_IDLE;
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      op_ff <= op_in;
      sa_ff <= sa_in;
      sb_ff <= sb_in;
      res_ff <= res_in;
      divz_ff <= divz_in;
   end

   assign done = (state_ff == A_DONE);
   assign divz = divz_ff;
   assign result = res_ff;
endmodule

// ----- rtl/core/pee_datapath.sv -----
// ----------------------------------------------------------------------------
// pee_datapath
// Operand stack in RAM, stack pointer, operand registers and ALU.
// ----------------------------------------------------------------------------
module pee_datapath #(
   parameter int STACK_DEPTH = 64,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pee_pkg::cmd_type      cmd,
   input  logic signed [31:0]    operand,
   input  logic [2:0]            op_code,
   output pee_pkg::sts_type      sts,
   output logic [DATA_WIDTH-1:0] rd_value
);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int NW = $clog2(STACK_DEPTH + 1);

   logic [NW-1:0]         cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] a_ff, b_ff, alu_res, rd_data, wr_data, opnd_ext;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic                  wr_en, alu_done, alu_divz;
   logic [NW-1:0]         idx_b, idx_a;

   assign opnd_ext = DATA_WIDTH'({{32{operand[31]}}, operand});
   assign idx_b = cnt_ff - NW'(1);
   assign idx_a = cnt_ff - NW'(2);

   always_comb begin
      rd_addr = '0;
      if (cmd.rd_b) rd_addr = idx_b[AW-1:0];
      else if (cmd.rd_a) rd_addr = idx_a[AW-1:0];
      else if (cmd.rd_0) rd_addr = '0;
      wr_en = cmd.push | cmd.wr_res;
      wr_addr = cmd.push ? cnt_ff[AW-1:0] : idx_a[AW-1:0];
      wr_data = cmd.push ? opnd_ext : alu_res;
      cnt_in = cnt_ff;
      if (cmd.clear) cnt_in = '0;
      else if (cmd.push) cnt_in = cnt_ff + NW'(1);
      else if (cmd.wr_res) cnt_in = idx_b;
   end

   pee_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      if (cmd.cap_b) b_ff <= rd_data;
      if (cmd.cap_a) a_ff <= rd_data;
   end

   pee_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.start),
      .op_code (op_code),
      .a       (a_ff),
      .b       (b_ff),
      .done    (alu_done),
      .divz    (alu_divz),
      .result  (alu_res)
   );

   assign sts.full = (cnt_ff == NW'(STACK_DEPTH));
   assign sts.lt2  = (cnt_ff < NW'(2));
   assign sts.one  = (cnt_ff == NW'(1));
   assign sts.done = alu_done;
   assign sts.divz = alu_divz;
   assign rd_value = rd_data;
endmodule

// ----- rtl/core/pee_ctrl.sv -----
// ----------------------------------------------------------------------------
// pee_ctrl
// Token sequencer: handshakes, sticky error, command generation.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_core_assert.svh"
module pee_ctrl #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pee_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pee_pkg::rsp_type      rsp_data,
   output pee_pkg::cmd_type      cmd,
   output logic [2:0]            op_code,
   input  pee_pkg::sts_type      sts,
   input  logic [DATA_WIDTH-1:0] rd_value
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_RDA   = 7'b0000010,
      S_CAPA  = 7'b0000100,
      S_START = 7'b0001000,
      S_WAIT  = 7'b0010000,
      S_ENDRD = 7'b0100000,
      S_ENDW  = 7'b1000000
   } ctl_state_type;

   ctl_state_type    state_ff, state_in;
   logic [1:0]       err_ff, err_in;
   logic [2:0]       op_ff, op_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pee_pkg::rsp_type rsp_ff, rsp_in;
   logic             take;

   assign req_ready = (state_ff == S_IDLE);
   assign take = req_valid && req_ready;
   assign op_code = op_ff;

   always_comb begin
      state_in = state_ff;
      err_in = err_ff;
      op_in = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               op_in = req_data.op_code;
               if (req_data.req_type == pee_pkg::REQ_PUSH && err_ff == pee_pkg::ST_OK) begin
                  if (sts.full) err_in = pee_pkg::ST_OVERFLOW;
                  else cmd.push = 1'b1;
               end else if (req_data.req_type == pee_pkg::REQ_OP
                            && err_ff == pee_pkg::ST_OK) begin
                  if (sts.lt2 || req_data.op_code > pee_pkg::OP_REM) begin
                     err_in = pee_pkg::ST_MALFORMED;
                  end else begin
                     cmd.rd_b = 1'b1;
                     state_in = S_RDA;
                  end
               end else if (req_data.req_type == pee_pkg::REQ_END) begin
                  cmd.rd_0 = 1'b1;
                  state_in = S_ENDRD;
               end
            end
         end
         S_RDA: begin
            cmd.cap_b = 1'b1;
            cmd.rd_a = 1'b1;
            state_in = S_CAPA;
         end
         S_CAPA: begin
            cmd.cap_a = 1'b1;
            state_in = S_START;
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (sts.done) begin
               if (sts.divz) err_in = pee_pkg::ST_DIVZERO;
               else cmd.wr_res = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ENDRD: begin
            // wait for a free output register
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_ENDW;
            end
         end
         S_ENDW: begin
            rsp_valid_in = 1'b1;
            rsp_in.value = '0;
            rsp_in.status = err_ff;
            if (err_ff == pee_pkg::ST_OK) begin
               if (sts.one) rsp_in.value = 32'(rd_value);
               else rsp_in.status = pee_pkg::ST_MALFORMED;
            end
            cmd.clear = 1'b1;
            err_in = pee_pkg::ST_OK;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         err_ff <= pee_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `PEE_ASSERT_NXT(a_rsp_hold, reset, rsp_valid_ff && !rsp_ready, rsp_valid_ff && $stable(rsp_ff))
   `PEE_ASSERT_IMP(a_err_val, reset, rsp_valid_ff && rsp_ff.status != pee_pkg::ST_OK, rsp_ff.value == '0)
   `PEE_ASSERT_NXT(a_end_clr, reset, state_ff == S_ENDW, err_ff == pee_pkg::ST_OK && rsp_valid_ff)
endmodule

// ----- tb/postfix_expression_evaluator_checker.sv -----
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_checker
// Watches the token and result channels, keeps its own operand stack and
// sticky error, predicts the result of every end token and compares it.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  pee_pkg::req_type_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  pee_pkg::rsp_type      rsp_data,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import pee_pkg::*;

   localparam int DEPTH = 64;

   logic [31:0] calc_stack [DEPTH];
   int          calc_depth;
   logic [1:0]  calc_error;
   rsp_type     expected_results [$];

   function automatic logic [31:0] int_pow(logic [31:0] a, logic [31:0] b);
      logic [31:0] acc;
      logic [31:0] base;
      logic [31:0] e;
      acc  = 32'd1;
      base = a;
      e    = b;
      if (b[31]) begin
         if (a == 32'd1) return 32'd1;
         if (a == 32'hFFFF_FFFF) return b[0] ? 32'hFFFF_FFFF : 32'd1;
         return 32'd0;
      end
      while (e != 0) begin
         if (e[0]) acc = acc * base;
         base = base * base;
         e = e >> 1;
      end
      return acc;
   endfunction

   // Returns 0 on a zero divisor.
   function automatic bit alu_eval(logic [2:0] code, logic [31:0] a, logic [31:0] b,
                                   output logic [31:0] r);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      r = '0;
      case (code)
         OP_ADD: begin r = a + b; return 1; end
         OP_SUB: begin r = a - b; return 1; end
         OP_MUL: begin r = a * b; return 1; end
         OP_POW: begin r = int_pow(a, b); return 1; end
         default: ;
      endcase
      if (b == 0) return 0;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      if (code == OP_DIV) begin
         q = ma / mb;
         r = (a[31] != b[31]) ? -q : q;
      end else begin
         q = ma % mb;
         r = a[31] ? -q : q;
      end
      return 1;
   endfunction

   task automatic apply_token(req_type_type t);
      logic [31:0] r;
      rsp_type     res;
      case (t.req_type)
         REQ_PUSH: begin
            if (calc_error == ST_OK) begin
               if (calc_depth >= DEPTH) calc_error = ST_OVERFLOW;
               else begin
                  calc_stack[calc_depth] = t.operand;
                  calc_depth++;
               end
            end
         end
         REQ_OP: begin
            if (calc_error == ST_OK) begin
               if (calc_depth < 2 || t.op_code > OP_REM) calc_error = ST_MALFORMED;
               else if (!alu_eval(t.op_code, calc_stack[calc_depth-2],
                                  calc_stack[calc_depth-1], r))
                  calc_error = ST_DIVZERO;
               else begin
                  calc_depth--;
                  calc_stack[calc_depth-1] = r;
               end
            end
         end
         REQ_END: begin
            res.status = calc_error;
            res.value  = '0;
            if (calc_error == ST_OK) begin
               if (calc_depth == 1) res.value = calc_stack[0];
               else res.status = ST_MALFORMED;
            end
            expected_results.push_back(res);
            calc_depth = 0;
            calc_error = ST_OK;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         calc_depth = 0;
         calc_error = ST_OK;
         expected_results.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         // result check first: the same-edge end token cannot produce it yet
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result value=%0d status=%0d", $time,
                        rsp_data.value, rsp_data.status);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_results.pop_front();
               if (exp_r !== rsp_data) begin
                  $display("%0t: mismatch expected value=%0d status=%0d %s value=%0d status=%0d",
                           $time, exp_r.value, exp_r.status, "actual",
                           rsp_data.value, rsp_data.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) apply_token(req_data);
         pending_count <= expected_results.size();
      end
   end
endmodule

// ----- tb/tb_postfix_expression_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator_core
// Drives directed and random postfix token streams with random idling and a
// long result stall; a checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator_core;
   timeunit 1ns;
   timeprecision 1ps;
   import pee_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_type_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_type      rsp_data;
   int           fail_count;
   int           pending_count;

   // idle percentages per phase; hold_off forces a long result stall
   int  send_idle_pct = 30;
   int  recv_idle_pct = 64;
   bit  hold_off = 1'b0;
   int  quiet_cycles = 0;

   always #5 clock = ~clock;

   postfix_expression_evaluator_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   postfix_expression_evaluator_checker CHECK (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // result side: random stalls, or a hard hold-off
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog: cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // one token; valid stays high across back-to-back transactions
   task automatic send_token(logic [1:0] kind, logic [31:0] opnd, logic [2:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data.req_type <= kind;
      req_data.operand  <= opnd;
      req_data.op_code  <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(5))
         0: return $urandom_range(7) - 3;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return $urandom_range(40);
         default: return $urandom;
      endcase
   endfunction

   // well-formed expression of n operands, occasionally broken
   task automatic send_expression(int n);
      int depth;
      logic [2:0] code;
      depth = 0;
      for (int i = 0; i < n; i++) begin
         send_token(REQ_PUSH, rand_operand(), 3'($urandom));
         depth++;
         while (depth >= 2 && $urandom_range(2) == 0) begin
            code = 3'($urandom_range(5));
            if ($urandom_range(30) == 0) code = 3'($urandom_range(7, 6));
            send_token(REQ_OP, $urandom, code);
            depth--;
         end
      end
      while (depth >= 2) begin
         send_token(REQ_OP, $urandom, 3'($urandom_range(5)));
         depth--;
      end
      if ($urandom_range(9) == 0) send_token(REQ_OP, $urandom, 3'($urandom_range(5)));
      if ($urandom_range(19) == 0) send_token(2'd3, $urandom, 3'($urandom));
      send_token(REQ_END, $urandom, 3'($urandom));
   endtask

   task automatic random_phase(int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(9))
            0: begin
               send_token(2'($urandom_range(3)), rand_operand(), 3'($urandom));
               sent++;
            end
            default: begin
               send_expression($urandom_range(1, 6));
               sent += 8;
            end
         endcase
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: each operator and the corner cases
      send_token(REQ_PUSH, 32'h7FFF_FFFF, OP_ADD);
      send_token(REQ_PUSH, 32'd1, OP_ADD);
      send_token(REQ_OP, 32'd0, OP_ADD);            // wraps
      send_token(REQ_PUSH, 32'd3, OP_ADD);
      send_token(REQ_OP, 32'd0, OP_SUB);
      send_token(REQ_PUSH, 32'hFFFF_FFFD, OP_ADD);
      send_token(REQ_OP, 32'd0, OP_MUL);
      send_token(REQ_END, 32'd0, OP_ADD);
      send_token(REQ_PUSH, 32'h8000_0000, OP_ADD);   // min / -1
      send_token(REQ_PUSH, 32'hFFFF_FFFF, OP_ADD);
      send_token(REQ_OP, 32'd0, OP_DIV);
      send_token(REQ_PUSH, 32'hFFFF_FFFF, OP_ADD);
      send_token(REQ_OP, 32'd0, OP_REM);
      send_token(REQ_END, 32'd0, OP_ADD);
      send_token(REQ_PUSH, 32'd0, OP_ADD);           // zero to the zero
      send_token(REQ_PUSH, 32'd0, OP_ADD);
      send_token(REQ_OP, 32'd0, OP_POW);
      send_token(REQ_PUSH, 32'hFFFF_FFFB, OP_ADD);   // negative exponent
      send_token(REQ_OP, 32'd0, OP_POW);
      send_token(REQ_END, 32'd0, OP_ADD);
      send_token(REQ_PUSH, 32'd5, OP_ADD);           // zero divisor
      send_token(REQ_PUSH, 32'd0, OP_ADD);
      send_token(REQ_OP, 32'd0, OP_DIV);
      send_token(REQ_END, 32'd0, OP_ADD);
      send_token(REQ_OP, 32'd0, OP_ADD);             // too few operands
      send_token(REQ_END, 32'd0, OP_ADD);
      send_token(REQ_PUSH, 32'd1, OP_ADD);           // unknown operator
      send_token(REQ_PUSH, 32'd1, OP_ADD);
      send_token(REQ_OP, 32'd0, 3'd7);
      send_token(2'd3, 32'd0, OP_ADD);
      send_token(REQ_END, 32'd0, OP_ADD);
      for (int i = 0; i < 65; i++) send_token(REQ_PUSH, $urandom, OP_ADD); // overflow
      send_token(REQ_END, 32'd0, OP_ADD);
      send_token(REQ_END, 32'd0, OP_ADD);            // empty stack

      random_phase(350);

      // long result stall while tokens keep coming
      hold_off = 1'b1;
      fork
         repeat (400) @(posedge clock);
         random_phase(40);
      join_any
      hold_off = 1'b0;
      wait fork;

      send_idle_pct = 64;
      recv_idle_pct = 30;
      random_phase(400);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(400);

      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
